[rtl/tllbp_pkg.sv]
package tllbp_pkg;

  // Fixed field widths
  localparam int ADDRESS_BITS = 32;
  localparam int CNT_W        = 32;

  // Defaults for the top level's parameters
  localparam int DEF_INDEX_BITS   = 10;
  localparam int DEF_HISTORY_BITS = 5;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] branch_address;
    logic                    actual_taken;
  } in_beat_t;

  typedef struct packed {
    logic             predicted_taken;
    logic             prediction_correct;
    logic             index_collision;
    logic [CNT_W-1:0] correct_count;
    logic [CNT_W-1:0] incorrect_count;
    logic [CNT_W-1:0] collision_count;
  } out_beat_t;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

endpackage

[rtl/two_level_local_branch_predictor_core.sv]
// Channel  Direction  Handshake        Payload
// in_      input      in_valid/stall   in_beat  (branch_address, actual_taken)
// out_     output     out_valid/stall  out_beat (prediction, flags, three counts)
//
// Taking an item reads its history/tag entry into a register; the lookup state
// then predicts and writes the entry back. A new item is taken only when the
// previous one has left the lookup stage; a result may wait in the output
// register meanwhile. After reset, a clearing pass zeroes all 2**INDEX_BITS
// history/tag entries (1024 by default), one entry per cycle, with in_stall
// high. A stalled output holds its beat; the lookup stage waits until it drains.
module two_level_local_branch_predictor_core
  import tllbp_pkg::*;
#(
  parameter int INDEX_BITS   = DEF_INDEX_BITS,
  parameter int HISTORY_BITS = DEF_HISTORY_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam int IDX_COUNT = 1 << INDEX_BITS;
  localparam int PAT_COUNT = 1 << HISTORY_BITS;
  localparam int ENTRY_W   = ADDRESS_BITS + HISTORY_BITS;

  // Controller
  state_t state_r, state_nxt;
  logic [INDEX_BITS-1:0] clr_idx_r;

  // Item held through the lookup
  logic [ADDRESS_BITS-1:0] addr_r;
  logic                    taken_r;

  // History/tag memory: {tag, history} per index
  logic [ENTRY_W-1:0]    mem [IDX_COUNT];
  logic [ENTRY_W-1:0]    rdata_r;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;

  // Pattern bits, small enough for flops
  logic [PAT_COUNT-1:0] pat_r;

  // Counters
  logic [CNT_W-1:0] hits_r, misses_r, clashes_r;
  logic [CNT_W-1:0] hits_nxt, misses_nxt, clashes_nxt;

  // Output register
  logic      out_valid_r;
  out_beat_t out_beat_r;

  // Lookup datapath
  logic                    accept;
  logic                    lookup_go;
  logic [HISTORY_BITS-1:0] rd_hist;
  logic [ADDRESS_BITS-1:0] rd_tag;
  logic [HISTORY_BITS-1:0] hist_nxt;
  logic                    pred;
  logic                    ok;
  logic                    clash;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign lookup_go = (state_r == ST_LOOKUP) && (!out_valid_r || !out_stall);

  assign rd_hist  = rdata_r[HISTORY_BITS-1:0];
  assign rd_tag   = rdata_r[ENTRY_W-1 -: ADDRESS_BITS];
  assign pred     = pat_r[rd_hist];
  assign ok       = (pred == taken_r);
  assign clash    = (rd_tag != addr_r);
  assign hist_nxt = HISTORY_BITS'({rd_hist, taken_r});

  // Saturating counter updates
  always_comb begin
    hits_nxt    = hits_r;
    misses_nxt  = misses_r;
    clashes_nxt = clashes_r;
    if (clash) begin
      if (clashes_r != '1) clashes_nxt = clashes_r + 1'b1;
    end else if (ok) begin
      if (hits_r != '1) hits_nxt = hits_r + 1'b1;
    end else begin
      if (misses_r != '1) misses_nxt = misses_r + 1'b1;
    end
  end

  // Memory write port: clearing pass or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (lookup_go) begin
      mem_we    = 1'b1;
      mem_waddr = addr_r[INDEX_BITS-1:0];
      mem_wdata = {addr_r, hist_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) rdata_r <= mem[in_beat.branch_address[INDEX_BITS-1:0]];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_idx_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept) state_nxt = ST_LOOKUP;
      ST_LOOKUP: if (lookup_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      pat_r       <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      clashes_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
      if (lookup_go) begin
        pat_r[rd_hist] <= taken_r;
        hits_r         <= hits_nxt;
        misses_r       <= misses_nxt;
        clashes_r      <= clashes_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r  <= in_beat.branch_address;
      taken_r <= in_beat.actual_taken;
    end
    if (lookup_go) begin
      out_beat_r.predicted_taken    <= pred;
      out_beat_r.prediction_correct <= ok;
      out_beat_r.index_collision    <= clash;
      out_beat_r.correct_count      <= hits_nxt;
      out_beat_r.incorrect_count    <= misses_nxt;
      out_beat_r.collision_count    <= clashes_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule
